// ===== src/http_body_dechunker_core_assert.svh =====
// Assertion macros shared by the body dechunker RTL.
`ifndef HTTP_BODY_DECHUNKER_CORE_ASSERT_SVH
`define HTTP_BODY_DECHUNKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define HDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HDC_ASSERT(label, clk, rst_n, prop, msg)

`define HDC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== src/hdc_pkg.sv =====
package hdc_pkg;

    localparam int SIZE_DIGITS = 8;
    localparam logic [35:0] SIZE_LIMIT = (SIZE_DIGITS >= 8) ? 36'hFFFF_FFFF :
        ((36'd1 << (4 * SIZE_DIGITS)) - 36'd1);

    localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [1:0] {
        CFG_CHUNKED  = 2'd0,
        CFG_LENGTH   = 2'd1,
        CFG_MAX_BODY = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        FLT_NONE      = 2'd0,
        FLT_BAD_REQ   = 2'd1,
        FLT_TOO_LARGE = 2'd2
    } t_fault;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_LEN_END  = 4'd1,
        PH_LEN_CR   = 4'd2,
        PH_EXT      = 4'd3,
        PH_SIZE_CR  = 4'd4,
        PH_DATA     = 4'd5,
        PH_DATA_END = 4'd6,
        PH_DATA_CR  = 4'd7,
        PH_ZERO_CR  = 4'd8,
        PH_FINAL    = 4'd9,
        PH_FINAL_CR = 4'd10,
        PH_DONE     = 4'd11
    } t_phase;

    typedef struct packed {
        logic        chunked_mode;
        logic [31:0] content_length;
        logic [31:0] max_body_size;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] chunk_length;
        logic [31:0] chunk_taken;
        logic [31:0] body_taken;
        t_fault      fault;
    } t_state;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       body_done;
        t_fault     error_code;
    } t_result;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

endpackage

// ===== src/hdc_step.sv =====
module hdc_step import hdc_pkg::*; (
    input  t_cfg       i_cfg,
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_result    o_result
);

    logic        w_is_cr;
    logic        w_is_lf;
    logic [4:0]  w_hex;
    logic [35:0] w_size_acc;
    logic [31:0] w_body_inc;
    logic [31:0] w_chunk_inc;
    logic        w_len_open;
    logic        w_data_full;
    logic        w_valid;
    t_state      n_state;

    assign w_is_cr     = (i_byte == CH_CR);
    assign w_is_lf     = (i_byte == CH_LF);
    assign w_hex       = hex_decode(i_byte);
    assign w_size_acc  = {i_state.chunk_length, w_hex[3:0]};
    assign w_body_inc  = i_state.body_taken + 32'd1;
    assign w_chunk_inc = i_state.chunk_taken + 32'd1;
    assign w_len_open  = (i_state.body_taken < i_cfg.content_length);
    assign w_data_full = (i_state.body_taken >= i_cfg.max_body_size);

    always_comb begin
        w_valid = 1'b0;
        if (i_state.fault == FLT_NONE) begin
            if (i_state.phase == PH_START && !i_cfg.chunked_mode && w_len_open) begin
                w_valid = 1'b1;
            end else if (i_state.phase == PH_DATA && !w_data_full &&
                         i_state.chunk_taken < i_state.chunk_length) begin
                w_valid = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = i_state;
        if (i_state.fault == FLT_NONE) begin
            unique case (i_state.phase)
                PH_START: begin
                    if (!i_cfg.chunked_mode) begin
                        if (w_len_open) begin
                            n_state.body_taken = w_body_inc;
                            if (w_body_inc == i_cfg.content_length) begin
                                n_state.phase = PH_LEN_END;
                            end
                        end else if (w_is_cr) begin
                            n_state.phase = PH_LEN_CR;
                        end else if (w_is_lf) begin
                            n_state.phase = PH_DONE;
                        end else begin
                            n_state.fault = FLT_TOO_LARGE;
                        end
                    end else if (w_is_cr || w_is_lf) begin
                        n_state.chunk_taken = 32'd0;
                        if (i_state.chunk_length == 32'd0) begin
                            n_state.phase = w_is_cr ? PH_ZERO_CR : PH_FINAL;
                        end else begin
                            n_state.phase = w_is_cr ? PH_SIZE_CR : PH_DATA;
                        end
                    end else if (i_byte == CH_SEMI) begin
                        n_state.chunk_taken = 32'd0;
                        n_state.phase       = PH_EXT;
                    end else if (!w_hex[4]) begin
                        n_state.fault = FLT_BAD_REQ;
                    end else if (w_size_acc > SIZE_LIMIT) begin
                        n_state.chunk_length = SIZE_LIMIT[31:0];
                        n_state.fault        = FLT_TOO_LARGE;
                    end else begin
                        n_state.chunk_length = w_size_acc[31:0];
                    end
                end
                PH_LEN_END, PH_FINAL: begin
                    if (w_is_cr) begin
                        n_state.phase = (i_state.phase == PH_FINAL) ? PH_FINAL_CR : PH_LEN_CR;
                    end else if (w_is_lf) begin
                        n_state.phase = PH_DONE;
                    end else begin
                        n_state.fault = FLT_TOO_LARGE;
                    end
                end
                PH_LEN_CR, PH_FINAL_CR: begin
                    if (w_is_lf) begin
                        n_state.phase = PH_DONE;
                    end else begin
                        n_state.fault = FLT_BAD_REQ;
                    end
                end
                PH_EXT: begin
                    if (w_is_cr || w_is_lf) begin
                        n_state.chunk_taken = 32'd0;
                        if (i_state.chunk_length == 32'd0) begin
                            n_state.phase = w_is_cr ? PH_ZERO_CR : PH_FINAL;
                        end else begin
                            n_state.phase = w_is_cr ? PH_SIZE_CR : PH_DATA;
                        end
                    end
                end
                PH_SIZE_CR: begin
                    if (w_is_lf) begin
                        n_state.phase = PH_DATA;
                    end else begin
                        n_state.fault = FLT_BAD_REQ;
                    end
                end
                PH_DATA: begin
                    if (w_data_full) begin
                        n_state.fault = FLT_TOO_LARGE;
                    end else if (i_state.chunk_taken < i_state.chunk_length) begin
                        n_state.chunk_taken = w_chunk_inc;
                        n_state.body_taken  = w_body_inc;
                        if (w_chunk_inc == i_state.chunk_length) begin
                            n_state.phase = PH_DATA_END;
                        end
                    end else if (w_is_cr) begin
                        n_state.phase = PH_DATA_CR;
                    end else if (w_is_lf) begin
                        n_state.phase = PH_START;
                    end else begin
                        n_state.fault = FLT_TOO_LARGE;
                    end
                end
                PH_DATA_END: begin
                    if (w_is_cr) begin
                        n_state.phase = PH_DATA_CR;
                    end else if (w_is_lf) begin
                        n_state.phase = PH_START;
                    end else begin
                        n_state.fault = FLT_TOO_LARGE;
                    end
                end
                PH_DATA_CR, PH_ZERO_CR: begin
                    if (w_is_lf) begin
                        n_state.phase = (i_state.phase == PH_ZERO_CR) ? PH_FINAL : PH_START;
                    end else begin
                        n_state.fault = FLT_BAD_REQ;
                    end
                end
                default: begin
                end
            endcase

            // A finished chunk hands back to a fresh size line.
            if (n_state.phase == PH_START && n_state.fault == FLT_NONE &&
                i_cfg.chunked_mode && !w_valid && w_is_lf &&
                n_state.chunk_taken == n_state.chunk_length &&
                n_state.chunk_length != 32'd0) begin
                n_state.chunk_length = 32'd0;
                n_state.chunk_taken  = 32'd0;
            end
        end
    end

    assign o_state = n_state;

    always_comb begin
        o_result.data_valid = w_valid;
        o_result.data_byte  = w_valid ? i_byte : 8'd0;
        o_result.body_done  = (n_state.phase == PH_DONE);
        o_result.error_code = n_state.fault;
    end

endmodule

// ===== src/http_body_dechunker_core.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata: in_byte
// m_axis    out  16+1   tdata: data_byte, body_done, error_code; tuser: data_valid
// cfg       in   2+32   register index and write data
//
// One byte is taken every cycle while m_axis does not stall; each result passes through the input and result registers.
// The decoder state updates in one pass of hdc_step between input and result registers.
// Synchronous active-low reset restores the configuration defaults and clears the decoder state and the valid flags.
// A stall on m_axis holds the result register and backs up through the input register.
`include "http_body_dechunker_core_assert.svh"

module http_body_dechunker_core import hdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] data_byte, [8] body_done, [10:9] error_code
    output logic [0:0]  o_m_axis_tuser,   // [0] data_valid
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       w_advance;
    logic       w_in_take;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    hdc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chunked_mode   <= 1'b0;
            r_cfg.content_length <= 32'd0;
            r_cfg.max_body_size  <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CHUNKED:  r_cfg.chunked_mode   <= i_cfg_data[0];
                CFG_LENGTH:   r_cfg.content_length <= i_cfg_data;
                CFG_MAX_BODY: r_cfg.max_body_size  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_START, chunk_length: 32'd0, chunk_taken: 32'd0,
                             body_taken: 32'd0, fault: FLT_NONE};
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {5'd0, r_out.error_code, r_out.body_done, r_out.data_byte};
    assign o_m_axis_tuser[0] = r_out.data_valid;

    `HDC_ASSERT(a_fault_sticky, i_clk, i_rst_n, (r_state.fault != FLT_NONE) |=> $stable(r_state.fault), "decoder fault changed after being set")
    `HDC_ASSERT(a_done_sticky, i_clk, i_rst_n, (r_state.phase == PH_DONE) |=> (r_state.phase == PH_DONE), "body done state was left")
    `HDC_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_m_axis_tready) |-> !w_advance, "result register overwritten while stalled")
    `HDC_ASSERT(a_payload_clean, i_clk, i_rst_n, (r_out_valid && r_out.data_valid) |-> (r_out.error_code == FLT_NONE && !r_out.body_done), "payload byte reported with error or done")
    `HDC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_out_valid && !r_in_valid), "pipeline not empty after reset")

endmodule

// ===== tb/sv/http_body_dechunker_core_tb.sv =====
module http_body_dechunker_core_tb;
    import hdc_pkg::*;

    typedef struct {
        logic        is_write;
        t_cfg_index  reg_sel;
        logic [31:0] value;
        logic [7:0]  in_byte;
        logic        typed;
        t_result     want;
    } t_plan_row;

    localparam t_result NO_WANT = '{1'b0, 8'h00, 1'b0, FLT_NONE};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [15:0] o_m_axis_tdata;
    wire  [0:0]  o_m_axis_tuser;

    http_body_dechunker_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    logic        cfg_chunked = 1'b0;
    logic [31:0] cfg_length = 32'd0;
    logic [31:0] cfg_max_body = MAX_BODY_RESET;

    t_phase      dec_phase = PH_START;
    logic [31:0] dec_len = 32'd0;
    logic [31:0] dec_got = 32'd0;
    logic [31:0] dec_total = 32'd0;
    t_fault      dec_fault = FLT_NONE;

    t_result     decoded_queue [$];
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          failures = 0;
    int          burst_left = 0;
    int          rx_left = 0;
    int          rx_style = 0;
    logic [1:0]  rx_tick = 2'd0;
    t_plan_row   plan [24];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic void take_break(input logic [7:0] b, input t_phase on_cr,
                                       input t_phase on_lf, input t_fault err);
        if (b == CH_CR) begin
            dec_phase = on_cr;
        end else if (b == CH_LF) begin
            dec_phase = on_lf;
        end else begin
            dec_fault = err;
        end
    endfunction

    function automatic void take_lf(input logic [7:0] b, input t_phase on_lf);
        if (b == CH_LF) begin
            dec_phase = on_lf;
        end else begin
            dec_fault = FLT_BAD_REQ;
        end
    endfunction

    function automatic void end_size_line(input logic [7:0] b);
        dec_got = 32'd0;
        if (dec_len == 32'd0) begin
            dec_phase = (b == CH_CR) ? PH_ZERO_CR : PH_FINAL;
        end else begin
            dec_phase = (b == CH_CR) ? PH_SIZE_CR : PH_DATA;
        end
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b);
        logic        passed;
        int          d;
        logic [35:0] acc;
        t_result     r;
        passed = 1'b0;
        if (dec_fault == FLT_NONE) begin
            case (dec_phase)
                PH_START: begin
                    if (!cfg_chunked) begin
                        if (dec_total < cfg_length) begin
                            passed = 1'b1;
                            dec_total = dec_total + 32'd1;
                            if (dec_total == cfg_length) dec_phase = PH_LEN_END;
                        end else begin
                            take_break(b, PH_LEN_CR, PH_DONE, FLT_TOO_LARGE);
                        end
                    end else if (b == CH_CR || b == CH_LF) begin
                        end_size_line(b);
                    end else if (b == CH_SEMI) begin
                        dec_got = 32'd0;
                        dec_phase = PH_EXT;
                    end else begin
                        d = hex_digit(b);
                        if (d < 0) begin
                            dec_fault = FLT_BAD_REQ;
                        end else begin
                            acc = {dec_len, 4'(d)};
                            if (acc > SIZE_LIMIT) begin
                                dec_len = SIZE_LIMIT[31:0];
                                dec_fault = FLT_TOO_LARGE;
                            end else begin
                                dec_len = acc[31:0];
                            end
                        end
                    end
                end
                PH_LEN_END:  take_break(b, PH_LEN_CR, PH_DONE, FLT_TOO_LARGE);
                PH_LEN_CR:   take_lf(b, PH_DONE);
                PH_EXT: begin
                    if (b == CH_CR || b == CH_LF) end_size_line(b);
                end
                PH_SIZE_CR:  take_lf(b, PH_DATA);
                PH_DATA: begin
                    if (dec_total >= cfg_max_body) begin
                        dec_fault = FLT_TOO_LARGE;
                    end else if (dec_got < dec_len) begin
                        passed = 1'b1;
                        dec_got = dec_got + 32'd1;
                        dec_total = dec_total + 32'd1;
                        if (dec_got == dec_len) dec_phase = PH_DATA_END;
                    end else begin
                        take_break(b, PH_DATA_CR, PH_START, FLT_TOO_LARGE);
                    end
                end
                PH_DATA_END: take_break(b, PH_DATA_CR, PH_START, FLT_TOO_LARGE);
                PH_DATA_CR:  take_lf(b, PH_START);
                PH_ZERO_CR:  take_lf(b, PH_FINAL);
                PH_FINAL:    take_break(b, PH_FINAL_CR, PH_DONE, FLT_TOO_LARGE);
                PH_FINAL_CR: take_lf(b, PH_DONE);
                default: ;
            endcase
            if (dec_phase == PH_START && dec_fault == FLT_NONE && cfg_chunked && !passed &&
                b == CH_LF && dec_got == dec_len && dec_len != 32'd0) begin
                dec_len = 32'd0;
                dec_got = 32'd0;
            end
        end
        r.data_valid = passed;
        r.data_byte = passed ? b : 8'h00;
        r.body_done = (dec_phase == PH_DONE);
        r.error_code = dec_fault;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        decoded_queue.insert(decoded_queue.size(), decode_byte(b));
        bytes_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (decoded_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index sel, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (sel)
            CFG_CHUNKED:  cfg_chunked = v[0];
            CFG_LENGTH:   cfg_length = v;
            CFG_MAX_BODY: cfg_max_body = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_break();
        if ($urandom_range(0, 1) == 1) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_size(input logic [31:0] value);
        int         digits;
        int         i;
        logic [7:0] xb;
        digits = 0;
        for (i = 0; i < 8; i++) begin
            if ((value >> (4 * i)) != 32'd0) digits = i + 1;
        end
        repeat ($urandom_range(0, 2)) send_byte(8'h30);
        for (i = digits - 1; i >= 0; i--) begin
            send_byte(hex_char(value[4 * i +: 4], 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_byte(CH_SEMI);
            repeat ($urandom_range(0, 5)) begin
                xb = 8'($urandom_range(0, 255));
                if (xb == CH_CR || xb == CH_LF) xb = 8'h3D;
                send_byte(xb);
            end
        end
        send_break();
    endtask

    task automatic send_chunk(input int n);
        int         i;
        logic       flip;
        logic [7:0] d;
        flip = (n >= 2) && ($urandom_range(0, 9) == 0);
        send_size(n);
        for (i = 0; i < n; i++) begin
            if (flip && i == n / 2) begin
                drain_results();
                write_reg(CFG_CHUNKED, 32'd0);
            end
            d = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) d = ($urandom_range(0, 1) == 1) ? CH_CR : CH_LF;
            send_byte(d);
        end
        if (flip) begin
            drain_results();
            write_reg(CFG_CHUNKED, 32'd1);
        end
        send_break();
    endtask

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_tick == 2'd0);
        endcase
        rx_tick <= rx_tick + 2'd1;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && m_axis_tready) begin
            if (decoded_queue.size() == 0) begin
                $display("%0t unexpected result: expected none, actual tdata %h tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                failures++;
            end else begin
                want = decoded_queue.pop_front();
                results_seen++;
                if (o_m_axis_tuser[0] !== want.data_valid) begin
                    $display("%0t data_valid mismatch: expected %b, actual %b",
                             $time, want.data_valid, o_m_axis_tuser[0]);
                    failures++;
                end
                if (o_m_axis_tdata[7:0] !== want.data_byte) begin
                    $display("%0t data_byte mismatch: expected %h, actual %h",
                             $time, want.data_byte, o_m_axis_tdata[7:0]);
                    failures++;
                end
                if (o_m_axis_tdata[8] !== want.body_done) begin
                    $display("%0t body_done mismatch: expected %b, actual %b",
                             $time, want.body_done, o_m_axis_tdata[8]);
                    failures++;
                end
                if (o_m_axis_tdata[10:9] !== want.error_code) begin
                    $display("%0t error_code mismatch: expected %0d, actual %0d",
                             $time, want.error_code, o_m_axis_tdata[10:9]);
                    failures++;
                end
            end
        end
    end

    initial begin
        int         i;
        int         k;
        int         n;
        int         ending;
        logic [7:0] b;

        plan = '{
            '{1'b1, CFG_LENGTH,   32'hFFFF_FFFF, 8'h00, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, FLT_NONE}},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'hFF, 1'b1, '{1'b1, 8'hFF, 1'b0, FLT_NONE}},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0D, 1'b1, '{1'b1, 8'h0D, 1'b0, FLT_NONE}},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0A, 1'b1, '{1'b1, 8'h0A, 1'b0, FLT_NONE}},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h3B, 1'b1, '{1'b1, 8'h3B, 1'b0, FLT_NONE}},
            '{1'b1, CFG_CHUNKED,  32'd1, 8'h00, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h30, 1'b1, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h31, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h3B, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h5A, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0D, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0A, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h80, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0D, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0A, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h30, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h32, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0A, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h00, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'hFF, 1'b0, NO_WANT},
            '{1'b0, CFG_CHUNKED,  32'd0, 8'h0A, 1'b0, NO_WANT},
            '{1'b1, CFG_MAX_BODY, 32'hFFFF_FFFF, 8'h00, 1'b0, NO_WANT},
            '{1'b1, CFG_CHUNKED,  32'd0, 8'h00, 1'b0, NO_WANT}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 24; i++) begin
            if (plan[i].is_write) begin
                drain_results();
                write_reg(plan[i].reg_sel, plan[i].value);
            end else begin
                send_byte(plan[i].in_byte);
                if (plan[i].typed) decoded_queue[decoded_queue.size() - 1] = plan[i].want;
            end
        end

        while (bytes_sent < 1300) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
                write_reg(CFG_LENGTH, ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF :
                          dec_total + 32'd2000 + $urandom_range(0, 32'h4000_0000));
                if ($urandom_range(0, 3) == 0) begin
                    write_reg(CFG_MAX_BODY, ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF :
                              dec_total + 32'd2000 + $urandom_range(0, 32'h4000_0000));
                end
                write_reg(CFG_CHUNKED, 32'd0);
                repeat ($urandom_range(4, 60)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                if (!cfg_chunked) begin
                    drain_results();
                    write_reg(CFG_CHUNKED, 32'd1);
                end
                repeat ($urandom_range(1, 4)) begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 80)
                                                    : $urandom_range(1, 12);
                    send_chunk(n);
                end
            end
        end

        // The body ends one way per run; every later byte must be ignored.
        drain_results();
        ending = $urandom_range(0, 8);
        if (ending >= 4) write_reg(CFG_CHUNKED, 32'd1);
        case (ending)
            0, 1, 2, 3: begin
                k = $urandom_range(1, 4);
                write_reg(CFG_LENGTH, (ending == 1) ? 32'd0 : dec_total + k);
                write_reg(CFG_CHUNKED, 32'd0);
                if (ending != 1) repeat (k) send_byte(8'($urandom_range(0, 255)));
                if (ending <= 1) begin
                    send_break();
                end else if (ending == 2) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
                    send_byte(b);
                end else begin
                    send_byte(CH_CR);
                    do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
                    send_byte(b);
                end
            end
            4: begin
                send_size(32'd0);
                send_break();
            end
            5: begin
                do b = 8'($urandom_range(0, 255));
                while (hex_digit(b) >= 0 || b == CH_CR || b == CH_LF || b == CH_SEMI);
                send_byte(b);
            end
            6: begin
                send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat (8) begin
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                end
            end
            7: begin
                write_reg(CFG_MAX_BODY, ($urandom_range(0, 1) == 1) ? 32'd0 : dec_total);
                send_size($urandom_range(1, 8));
                send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                n = $urandom_range(1, 8);
                send_size(n);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
                do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
                send_byte(b);
            end
        endcase
        repeat (16) send_byte(8'($urandom_range(0, 255)));

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d body bytes over length and chunked segments, %0d results compared.",
                 bytes_sent, results_seen);
        $display("Body closed by ending %0d, leaving phase %s and error %s.",
                 ending, dec_phase.name(), dec_fault.name());
        if (failures == 0 && decoded_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
